// ===== hdl/button_click_long_press_detector_assert.svh =====
// Assertion macros for the push-button qualifier.
// Used by the top level only; no other dependencies.
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcl assertion failed");

// Next-cycle implication, disabled in reset.
`define BCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcl assertion failed");

`endif

// ===== hdl/bcl_pkg.sv =====
// Shared types and constants for the push-button qualifier.
// No dependencies.
package bcl_pkg;

    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [MS_W-1:0] MS_RESET = MS_W'(1000);
    localparam logic [3:0]      RING_FULL  = 4'hf;
    localparam logic [3:0]      RING_EMPTY = 4'h0;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIMEOUT = CFG_IDX_W'(1);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_HELD  = 2'd1,
        EV_CLICK = 2'd2,
        EV_LONG  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        PD_ACTIVE = 2'd0,
        PD_IDLE   = 2'd1,
        PD_CLICK  = 2'd2,
        PD_LONG   = 2'd3
    } pend_t;

    typedef struct packed {
        op_t               op;
        logic              pressed;
        logic [TIME_W-1:0] time_ms;
    } item_t;

    // Configuration write as seen by the core.
    typedef struct packed {
        logic                 wr;
        logic [CFG_IDX_W-1:0] index;
        logic [MS_W-1:0]      data;
    } cfg_wr_t;

endpackage

// ===== hdl/bcl_in_stage.sv =====
// Input register of the push-button qualifier: holds one accepted beat.
// Depends on bcl_pkg.
module bcl_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  bcl_pkg::item_t  in_item,
    input  logic            advance,
    output logic            valid,
    output bcl_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    bcl_pkg::item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_fire) begin
            item_reg <= in_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ===== hdl/bcl_core.sv =====
// Qualifier state and per-item update: sample ring, change stamp, held flag,
// pending event and the two millisecond limits. Depends on bcl_pkg.
module bcl_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  bcl_pkg::cfg_wr_t  cfg,
    input  logic              advance,
    input  bcl_pkg::item_t    item,
    output bcl_pkg::event_t   event_res,
    output logic              held,
    output bcl_pkg::pend_t    pending
);

    logic [bcl_pkg::MS_W-1:0]   long_ms_reg;
    logic [bcl_pkg::MS_W-1:0]   click_ms_reg;
    logic [3:0]                 ring_reg,   ring_next;
    logic [1:0]                 idx_reg,    idx_next;
    logic                       last_reg,   last_next;
    logic [bcl_pkg::TIME_W-1:0] stamp_reg,  stamp_next;
    logic                       held_reg,   held_next;
    bcl_pkg::pend_t             pend_reg,   pend_next;
    bcl_pkg::event_t            ev;
    logic [bcl_pkg::TIME_W-1:0] age;

    // Elapsed time since the last level change, wraps mod 2^32.
    assign age = item.time_ms - stamp_reg;

    always_comb begin
        bcl_pkg::pend_t pv;
        pv         = pend_reg;
        ring_next  = ring_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        stamp_next = stamp_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        ev         = bcl_pkg::EV_NONE;
        if (item.op == bcl_pkg::OP_READ) begin
            case (pend_reg)
                bcl_pkg::PD_CLICK: begin
                    ev        = bcl_pkg::EV_CLICK;
                    pend_next = bcl_pkg::PD_IDLE;
                end
                bcl_pkg::PD_LONG: begin
                    ev        = bcl_pkg::EV_LONG;
                    pend_next = bcl_pkg::PD_IDLE;
                end
                default: begin
                    ev = held_reg ? bcl_pkg::EV_HELD : bcl_pkg::EV_NONE;
                end
            endcase
        end else begin
            ring_next[idx_reg] = item.pressed;
            idx_next = idx_reg + 2'd1;
            if (last_reg != item.pressed) begin
                // level change: record only
                last_next  = item.pressed;
                stamp_next = item.time_ms;
            end else if (ring_next == bcl_pkg::RING_FULL) begin
                if (!held_reg) begin
                    pv = bcl_pkg::PD_ACTIVE;
                end
                held_next = 1'b1;
                if (pv == bcl_pkg::PD_ACTIVE
                        && age > {{(bcl_pkg::TIME_W-bcl_pkg::MS_W){1'b0}}, long_ms_reg}) begin
                    pv = bcl_pkg::PD_LONG;
                end
                pend_next = pv;
            end else if (ring_next == bcl_pkg::RING_EMPTY) begin
                if (held_reg) begin
                    pv = (pend_reg == bcl_pkg::PD_ACTIVE) ? bcl_pkg::PD_CLICK
                                                          : bcl_pkg::PD_IDLE;
                end
                held_next = 1'b0;
                if (pv == bcl_pkg::PD_CLICK
                        && age > {{(bcl_pkg::TIME_W-bcl_pkg::MS_W){1'b0}}, click_ms_reg}) begin
                    pv = bcl_pkg::PD_IDLE;
                end
                pend_next = pv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_ms_reg  <= bcl_pkg::MS_RESET;
            click_ms_reg <= bcl_pkg::MS_RESET;
            ring_reg     <= 4'h0;
            idx_reg      <= 2'd0;
            last_reg     <= 1'b0;
            stamp_reg    <= '0;
            held_reg     <= 1'b0;
            pend_reg     <= bcl_pkg::PD_ACTIVE;
        end else begin
            if (cfg.wr && cfg.index == bcl_pkg::CFG_LONG_PRESS) begin
                long_ms_reg <= cfg.data;
            end
            if (cfg.wr && cfg.index == bcl_pkg::CFG_CLICK_TIMEOUT) begin
                click_ms_reg <= cfg.data;
            end
            if (advance) begin
                ring_reg  <= ring_next;
                idx_reg   <= idx_next;
                last_reg  <= last_next;
                stamp_reg <= stamp_next;
                held_reg  <= held_next;
                pend_reg  <= pend_next;
            end
        end
    end

    assign event_res = ev;
    assign held      = held_reg;
    assign pending   = pend_reg;

endmodule

// ===== hdl/button_click_long_press_detector.sv =====
// Push-button qualifier: click and long-press detection on sampled levels.
// Input beat: s_tuser = op (0 sample, 1 read); s_tdata = pressed, time_ms.
// Result beat: m_tdata = event_res (0 none, 1 held, 2 click, 3 long press).
// Config channel: cfg_index 0 = long_press_ms, 1 = click_timeout_ms, 16-bit
// data; other indexes are dropped. cfg_ready is always high; write only while
// no beat is in flight.
// Every input beat gives exactly one result beat, in order.
// An accepted beat goes into the input register, then through the state
// update into the result register, before its result shows on m_*.
// Throughput: one beat per cycle while m_tready stays high; the state update
// (one 32-bit subtract and compare) is combinational.
// Reset (aresetn low, synchronous): both channels empty, limits back to
// 1000 ms, ring, stamp and held flag cleared, nothing pending.
// When m_tready is low the result register holds; the input register keeps
// taking one more beat, then s_tready drops until the result is taken.
// Depends on bcl_pkg, bcl_in_stage, bcl_core and the assertion header.
`include "button_click_long_press_detector_assert.svh"

module button_click_long_press_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bcl_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] pressed, [32:1] time_ms
    input  logic                            s_tuser,   // [0] op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bcl_pkg::M_TDATA_W-1:0]   m_tdata,   // [1:0] event_res
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcl_pkg::MS_W-1:0]        cfg_data
);

    bcl_pkg::item_t   in_item;
    bcl_pkg::item_t   stage_item;
    bcl_pkg::cfg_wr_t cfg;
    bcl_pkg::event_t  core_ev;
    bcl_pkg::pend_t   pending;
    logic             stage_valid;
    logic             advance;
    logic             in_fire;
    logic             held;
    logic             out_valid_reg, out_valid_next;
    bcl_pkg::event_t  out_ev_reg;

    assign in_item.op      = bcl_pkg::op_t'(s_tuser);
    assign in_item.pressed = s_tdata[0];
    assign in_item.time_ms = s_tdata[bcl_pkg::TIME_W:1];

    assign cfg.wr    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign cfg_ready = 1'b1;

    // stage moves on when the result register is free or being drained
    assign advance  = stage_valid && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid || advance;
    assign in_fire  = s_tvalid && s_tready;

    bcl_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (in_item),
        .advance (advance),
        .valid   (stage_valid),
        .item    (stage_item)
    );

    bcl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (advance),
        .item      (stage_item),
        .event_res (core_ev),
        .held      (held),
        .pending   (pending)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (advance) begin
            out_ev_reg <= core_ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bcl_pkg::M_TDATA_W-2){1'b0}}, out_ev_reg};

    `BCL_ASSERT_NXT(a_sample_gives_none, aclk, aresetn,
        advance && stage_item.op == bcl_pkg::OP_SAMPLE,
        m_tvalid && m_tdata[1:0] == bcl_pkg::EV_NONE)
    `BCL_ASSERT_NXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    `BCL_ASSERT_IMP(a_long_only_held, aclk, aresetn, pending == bcl_pkg::PD_LONG, held)
    `BCL_ASSERT_IMP(a_click_only_released, aclk, aresetn,
        pending == bcl_pkg::PD_CLICK, !held)

endmodule
